@@ design/bsrp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bit stream run and pair statistics block.
// Holds sizing constants, the item function codes, shared types and helper functions.
package bsrp_pkg;

  localparam int RUN_LIMIT   = 128;
  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int BYTE_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int LEN_W       = 7;
  localparam int RUN_W       = $clog2(RUN_LIMIT + 1);
  localparam int HIST_AW     = $clog2(RUN_LIMIT);
  localparam int BIT_IDX_W   = $clog2(BYTE_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_DATA,
    ENG_ONE
  } eng_state_t;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [RUN_W-1:0]       run_t;
  typedef logic [HIST_AW-1:0]     hist_addr_t;
  typedef logic [OUT_WIDTH-1:0]   out_word_t;

  // Request from the bit engine to one histogram.
  typedef struct packed {
    logic       rmw;
    logic       rd;
    hist_addr_t addr;
  } hist_req_t;

  typedef struct packed {
    out_word_t byte_count;
    out_word_t ones_count;
    out_word_t zeros_count;
    out_word_t pair_00;
    out_word_t pair_01;
    out_word_t pair_10;
    out_word_t pair_11;
    out_word_t ones_run_bin;
    out_word_t zeros_run_bin;
    logic      ones_run_overflow;
    logic      zeros_run_overflow;
  } out_item_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

  function automatic run_t grow_run(input run_t r);
    return (int'(r) < RUN_LIMIT) ? r + run_t'(1) : r;
  endfunction

endpackage

@@ design/bsrp_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the bit stream run and pair statistics block.
// Depends on bsrp_pkg for the field widths.
interface bsrp_in_if;
  logic                          valid;
  logic                          ready;
  logic [bsrp_pkg::FUNC_W-1:0]   func;
  logic [bsrp_pkg::BYTE_W-1:0]   data_byte;
  logic [bsrp_pkg::LEN_W-1:0]    run_length;

  modport source(output valid, func, data_byte, run_length, input ready);
  modport sink(input valid, func, data_byte, run_length, output ready);
endinterface

interface bsrp_out_if;
  logic                  valid;
  logic                  ready;
  bsrp_pkg::out_word_t   byte_count;
  bsrp_pkg::out_word_t   ones_count;
  bsrp_pkg::out_word_t   zeros_count;
  bsrp_pkg::out_word_t   pair_00;
  bsrp_pkg::out_word_t   pair_01;
  bsrp_pkg::out_word_t   pair_10;
  bsrp_pkg::out_word_t   pair_11;
  bsrp_pkg::out_word_t   ones_run_bin;
  bsrp_pkg::out_word_t   zeros_run_bin;
  logic                  ones_run_overflow;
  logic                  zeros_run_overflow;

  modport source(output valid, byte_count, ones_count, zeros_count, pair_00, pair_01,
                 pair_10, pair_11, ones_run_bin, zeros_run_bin, ones_run_overflow,
                 zeros_run_overflow, input ready);
  modport sink(input valid, byte_count, ones_count, zeros_count, pair_00, pair_01,
               pair_10, pair_11, ones_run_bin, zeros_run_bin, ones_run_overflow,
               zeros_run_overflow, output ready);
endinterface

@@ design/bsrp_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bsrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/bsrp_hist.sv @@
`timescale 1ns / 1ps
// One run-length histogram: RAM, per-entry valid bits and the saturating
// read-modify-write path with write forwarding. Depends on bsrp_pkg and bsrp_ram.
module bsrp_hist (
  input  logic                clk,
  input  logic                rst_n,
  input  bsrp_pkg::hist_req_t req,
  output bsrp_pkg::cnt_t      bin
);

  logic [bsrp_pkg::RUN_LIMIT-1:0] valid_r;
  logic                           rmw_r;
  bsrp_pkg::hist_addr_t           addr_r;
  logic                           vld_q_r;
  logic                           fwd_r;
  logic                           fwd_nxt;
  bsrp_pkg::cnt_t                 fwd_data_r;
  bsrp_pkg::cnt_t                 rd_data;
  bsrp_pkg::cnt_t                 cur_val;
  bsrp_pkg::cnt_t                 wr_data;
  logic                           rd_en;

  assign rd_en = req.rmw | req.rd;

  bsrp_ram #(
    .WIDTH(bsrp_pkg::COUNT_WIDTH),
    .DEPTH(bsrp_pkg::RUN_LIMIT)
  ) u_ram (
    .clk  (clk),
    .we   (rmw_r),
    .waddr(addr_r),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(req.addr),
    .rdata(rd_data)
  );

  // An entry never written reads as zero. A read issued in the same cycle as a
  // write to the same entry takes the written value instead of the stale one.
  assign cur_val = fwd_r ? fwd_data_r : (vld_q_r ? rd_data : '0);
  assign wr_data = bsrp_pkg::sat_inc(cur_val);
  assign fwd_nxt = rmw_r && rd_en && (addr_r == req.addr);
  assign bin     = cur_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rmw_r   <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (rmw_r) begin
        valid_r[addr_r] <= 1'b1;
      end
      rmw_r <= req.rmw;
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= req.addr;
    vld_q_r    <= valid_r[req.addr];
    fwd_data_r <= wr_data;
  end

endmodule

@@ design/bit_stream_run_and_pair_statistics_core.sv @@
`timescale 1ns / 1ps
// Bit stream run and pair statistics. Data bytes are walked MSB first, one bit per
// cycle, the last bit waiting for room in the result stage; each bit closes at most
// one run (a histogram RMW). Flush, read and no-op items are handled in ENG_ONE; an
// item after a read cannot finish before the read's bins come back from the histogram
// RAMs in the cycle after the lookup. A result passes the result stage, then the output
// register. Synchronous active-low reset clears counters and bin flags.
module bit_stream_run_and_pair_statistics_core (
  input logic clk,
  input logic rst_n,
  bsrp_in_if.sink    in_chan,
  bsrp_out_if.source out_chan
);

  bsrp_pkg::eng_state_t state_r, state_nxt;
  bsrp_pkg::func_t      cur_func_r, cur_func_nxt;
  logic [bsrp_pkg::BYTE_W-1:0]    shift_r, shift_nxt;
  logic [bsrp_pkg::BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [bsrp_pkg::LEN_W-1:0]     len_r, len_nxt;

  bsrp_pkg::cnt_t bytes_r, bytes_nxt;
  bsrp_pkg::cnt_t ones_r, ones_nxt;
  bsrp_pkg::cnt_t zeros_r, zeros_nxt;
  bsrp_pkg::cnt_t pair_r [4];
  bsrp_pkg::cnt_t pair_nxt [4];
  logic           prev_r, prev_nxt;
  logic           have_prev_r, have_prev_nxt;
  bsrp_pkg::run_t open1_r, open1_nxt;
  bsrp_pkg::run_t open0_r, open0_nxt;
  logic           ovf1_r, ovf1_nxt;
  logic           ovf0_r, ovf0_nxt;

  bsrp_pkg::hist_req_t req1, req0;
  bsrp_pkg::cnt_t      bin1, bin0;

  bsrp_pkg::out_item_t res_r, res_nxt;
  logic                res_v_r, res_v_nxt;
  logic                res_pend_r, res_pend_nxt;
  logic                res_rdok_r, res_rdok_nxt;
  bsrp_pkg::out_item_t out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  logic       eng_last;
  logic       res_adv;
  logic       res_free;
  logic       step_en;
  logic       eng_fin;
  logic       in_ready;
  logic       accept;
  logic       cur_bit;
  logic [1:0] pair_idx;
  logic       len_ok;

  assign eng_last = ((state_r == bsrp_pkg::ENG_DATA) && (bit_idx_r == '1)) ||
                    (state_r == bsrp_pkg::ENG_ONE);
  assign res_adv  = res_v_r && !res_pend_r && (!out_v_r || out_chan.ready);
  assign res_free = !res_v_r || res_adv;
  // Only the final step of an item waits for room in the result stage.
  assign step_en  = (state_r != bsrp_pkg::ENG_IDLE) && (!eng_last || res_free);
  assign eng_fin  = step_en && eng_last;
  assign in_ready = rst_n &&
                    ((state_r == bsrp_pkg::ENG_IDLE) || (eng_last && res_free));
  assign accept   = in_chan.valid && in_ready;
  assign cur_bit  = shift_r[bsrp_pkg::BYTE_W-1];
  assign pair_idx = {prev_r, cur_bit};
  assign len_ok   = (len_r != '0) && (int'(len_r) < bsrp_pkg::RUN_LIMIT);

  // Next-state logic of the bit engine.
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      if (bsrp_pkg::func_t'(in_chan.func) == bsrp_pkg::FUNC_DATA) begin
        state_nxt = bsrp_pkg::ENG_DATA;
      end else begin
        state_nxt = bsrp_pkg::ENG_ONE;
      end
    end else if (eng_fin) begin
      state_nxt = bsrp_pkg::ENG_IDLE;
    end
  end

  // Datapath of the bit engine.
  always_comb begin
    cur_func_nxt  = cur_func_r;
    shift_nxt     = shift_r;
    bit_idx_nxt   = bit_idx_r;
    len_nxt       = len_r;
    bytes_nxt     = bytes_r;
    ones_nxt      = ones_r;
    zeros_nxt     = zeros_r;
    pair_nxt      = pair_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    open1_nxt     = open1_r;
    open0_nxt     = open0_r;
    ovf1_nxt      = ovf1_r;
    ovf0_nxt      = ovf0_r;
    req1          = '0;
    req0          = '0;
    if (step_en) begin
      case (state_r)
        bsrp_pkg::ENG_DATA: begin
          if (bit_idx_r == '0) begin
            bytes_nxt = bsrp_pkg::sat_inc(bytes_r);
          end
          if (have_prev_r) begin
            pair_nxt[pair_idx] = bsrp_pkg::sat_inc(pair_r[pair_idx]);
          end
          prev_nxt      = cur_bit;
          have_prev_nxt = 1'b1;
          shift_nxt     = shift_r << 1;
          bit_idx_nxt   = bit_idx_r + 1'b1;
          if (cur_bit) begin
            ones_nxt = bsrp_pkg::sat_inc(ones_r);
            if (open0_r != '0) begin
              if (int'(open0_r) >= bsrp_pkg::RUN_LIMIT) begin
                ovf0_nxt = 1'b1;
              end else begin
                req0.rmw  = 1'b1;
                req0.addr = bsrp_pkg::hist_addr_t'(open0_r);
              end
            end
            open0_nxt = '0;
            open1_nxt = bsrp_pkg::grow_run(open1_r);
          end else begin
            zeros_nxt = bsrp_pkg::sat_inc(zeros_r);
            if (open1_r != '0) begin
              if (int'(open1_r) >= bsrp_pkg::RUN_LIMIT) begin
                ovf1_nxt = 1'b1;
              end else begin
                req1.rmw  = 1'b1;
                req1.addr = bsrp_pkg::hist_addr_t'(open1_r);
              end
            end
            open1_nxt = '0;
            open0_nxt = bsrp_pkg::grow_run(open0_r);
          end
        end
        bsrp_pkg::ENG_ONE: begin
          case (cur_func_r)
            bsrp_pkg::FUNC_FLUSH: begin
              if (open1_r != '0) begin
                if (int'(open1_r) >= bsrp_pkg::RUN_LIMIT) begin
                  ovf1_nxt = 1'b1;
                end else begin
                  req1.rmw  = 1'b1;
                  req1.addr = bsrp_pkg::hist_addr_t'(open1_r);
                end
              end
              if (open0_r != '0) begin
                if (int'(open0_r) >= bsrp_pkg::RUN_LIMIT) begin
                  ovf0_nxt = 1'b1;
                end else begin
                  req0.rmw  = 1'b1;
                  req0.addr = bsrp_pkg::hist_addr_t'(open0_r);
                end
              end
              open1_nxt = '0;
              open0_nxt = '0;
            end
            bsrp_pkg::FUNC_READ: begin
              if (len_ok) begin
                req1.rd   = 1'b1;
                req1.addr = bsrp_pkg::hist_addr_t'(len_r);
                req0.rd   = 1'b1;
                req0.addr = bsrp_pkg::hist_addr_t'(len_r);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    if (accept) begin
      cur_func_nxt = bsrp_pkg::func_t'(in_chan.func);
      shift_nxt    = in_chan.data_byte;
      bit_idx_nxt  = '0;
      len_nxt      = in_chan.run_length;
    end
  end

  bsrp_hist u_hist_ones (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req1),
    .bin  (bin1)
  );

  bsrp_hist u_hist_zeros (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req0),
    .bin  (bin0)
  );

  // Result stage: the snapshot is taken from the values after the final step;
  // read bins arrive from the histogram RAMs in the cycle after it.
  always_comb begin
    res_nxt      = res_r;
    res_v_nxt    = res_v_r;
    res_pend_nxt = res_pend_r;
    res_rdok_nxt = res_rdok_r;
    if (res_pend_r) begin
      res_nxt.ones_run_bin  = res_rdok_r ? bsrp_pkg::out_word_t'(bin1) : '0;
      res_nxt.zeros_run_bin = res_rdok_r ? bsrp_pkg::out_word_t'(bin0) : '0;
      res_pend_nxt          = 1'b0;
    end
    if (res_adv) begin
      res_v_nxt = 1'b0;
    end
    if (eng_fin) begin
      res_v_nxt                  = 1'b1;
      res_pend_nxt               = (cur_func_r == bsrp_pkg::FUNC_READ);
      res_rdok_nxt               = len_ok;
      res_nxt.byte_count         = bsrp_pkg::out_word_t'(bytes_nxt);
      res_nxt.ones_count         = bsrp_pkg::out_word_t'(ones_nxt);
      res_nxt.zeros_count        = bsrp_pkg::out_word_t'(zeros_nxt);
      res_nxt.pair_00            = bsrp_pkg::out_word_t'(pair_nxt[0]);
      res_nxt.pair_01            = bsrp_pkg::out_word_t'(pair_nxt[1]);
      res_nxt.pair_10            = bsrp_pkg::out_word_t'(pair_nxt[2]);
      res_nxt.pair_11            = bsrp_pkg::out_word_t'(pair_nxt[3]);
      res_nxt.ones_run_bin       = '0;
      res_nxt.zeros_run_bin      = '0;
      res_nxt.ones_run_overflow  = ovf1_nxt;
      res_nxt.zeros_run_overflow = ovf0_nxt;
    end
  end

  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (res_adv) begin
      out_nxt   = res_r;
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsrp_pkg::ENG_IDLE;
      bytes_r     <= '0;
      ones_r      <= '0;
      zeros_r     <= '0;
      pair_r      <= '{default: '0};
      prev_r      <= 1'b0;
      have_prev_r <= 1'b0;
      open1_r     <= '0;
      open0_r     <= '0;
      ovf1_r      <= 1'b0;
      ovf0_r      <= 1'b0;
      res_v_r     <= 1'b0;
      res_pend_r  <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bytes_r     <= bytes_nxt;
      ones_r      <= ones_nxt;
      zeros_r     <= zeros_nxt;
      pair_r      <= pair_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      open1_r     <= open1_nxt;
      open0_r     <= open0_nxt;
      ovf1_r      <= ovf1_nxt;
      ovf0_r      <= ovf0_nxt;
      res_v_r     <= res_v_nxt;
      res_pend_r  <= res_pend_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_func_r <= cur_func_nxt;
    shift_r    <= shift_nxt;
    bit_idx_r  <= bit_idx_nxt;
    len_r      <= len_nxt;
    res_r      <= res_nxt;
    res_rdok_r <= res_rdok_nxt;
    out_r      <= out_nxt;
  end

  assign in_chan.ready               = in_ready;
  assign out_chan.valid              = out_v_r;
  assign out_chan.byte_count         = out_r.byte_count;
  assign out_chan.ones_count         = out_r.ones_count;
  assign out_chan.zeros_count        = out_r.zeros_count;
  assign out_chan.pair_00            = out_r.pair_00;
  assign out_chan.pair_01            = out_r.pair_01;
  assign out_chan.pair_10            = out_r.pair_10;
  assign out_chan.pair_11            = out_r.pair_11;
  assign out_chan.ones_run_bin       = out_r.ones_run_bin;
  assign out_chan.zeros_run_bin      = out_r.zeros_run_bin;
  assign out_chan.ones_run_overflow  = out_r.ones_run_overflow;
  assign out_chan.zeros_run_overflow = out_r.zeros_run_overflow;

endmodule

@@ design/bsrp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the bit stream run and pair statistics block, with its bind.
// Depends on bsrp_pkg and on the top level's ports.
module bsrp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input bsrp_pkg::out_word_t byte_count,
  input bsrp_pkg::out_word_t ones_count,
  input bsrp_pkg::out_word_t zeros_count,
  input bsrp_pkg::out_word_t pair_00,
  input bsrp_pkg::out_word_t pair_01,
  input bsrp_pkg::out_word_t pair_10,
  input bsrp_pkg::out_word_t pair_11
);

  // Below this many bytes no bit or pair counter can have saturated.
  localparam longint SAFE_BYTES = (bsrp_pkg::COUNT_WIDTH < 32) ?
                                  (longint'(1) << (bsrp_pkg::COUNT_WIDTH - 3)) :
                                  (longint'(1) << 29);

  logic        xfer;
  logic        unsat;
  logic [34:0] bit_sum;
  logic [34:0] pair_sum;

  assign xfer     = out_valid && out_ready;
  assign unsat    = longint'(byte_count) < SAFE_BYTES;
  assign bit_sum  = 35'(ones_count) + 35'(zeros_count);
  assign pair_sum = 35'(pair_00) + 35'(pair_01) + 35'(pair_10) + 35'(pair_11);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_count) && $stable(ones_count))
    else $error("stalled result changed");

  a_bits_per_byte: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && unsat |-> bit_sum == (35'(byte_count) << 3))
    else $error("ones plus zeros differ from eight bits per byte");

  a_pairs_per_bit: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && unsat && (byte_count != '0) |-> pair_sum + 35'd1 == bit_sum)
    else $error("pair total does not trail the bit total by one");

endmodule

bind bit_stream_run_and_pair_statistics_core bsrp_checker u_bsrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .byte_count (out_chan.byte_count),
  .ones_count (out_chan.ones_count),
  .zeros_count(out_chan.zeros_count),
  .pair_00    (out_chan.pair_00),
  .pair_01    (out_chan.pair_01),
  .pair_10    (out_chan.pair_10),
  .pair_11    (out_chan.pair_11)
);
